/* design/m4xf_pkg.sv */
// m4xf_pkg: types, constants and microcode rom of the 4x4 matrix transform unit
// no dependencies; used by the sequencer, the datapath and the top level
package m4xf_pkg;

	localparam logic signed [31:0] Q_ONE     = 32'sh0001_0000;
	localparam logic signed [63:0] RND_HALF  = 64'sh0000_0000_0000_8000;
	localparam logic signed [31:0] SAT_MAX   = 32'sh7fff_ffff;
	localparam logic signed [31:0] SAT_MIN   = 32'sh8000_0000;
	localparam int                 ACC_W     = 50;

	typedef enum logic [2:0] {
		OP_WR_CUR = 3'd0,
		OP_WR_OPD = 3'd1,
		OP_PREMUL = 3'd2,
		OP_XFORM  = 3'd3,
		OP_IDENT  = 3'd4
	} op_t;

	typedef enum logic [3:0] {
		U_FETCH   = 4'd0,
		U_TX      = 4'd1,
		U_TX_D1   = 4'd2,
		U_TX_D2   = 4'd3,
		U_TX_OUT  = 4'd4,
		U_PM      = 4'd5,
		U_PM_D1   = 4'd6,
		U_PM_D2   = 4'd7,
		U_PM_FLIP = 4'd8,
		U_ID      = 4'd9
	} upc_t;

	typedef enum logic [1:0] {
		J_GOTO = 2'd0,
		J_DISP = 2'd1,
		J_LOOP = 2'd2,
		J_WAIT = 2'd3
	} jmp_t;

	typedef struct packed {
		logic       rdy;
		logic       mac;
		logic       pm;
		logic       id_wr;
		logic       out_ld;
		logic       flip;
		jmp_t       jmp;
		logic [5:0] lim;
		upc_t       target;
	} uword_t;

	typedef struct packed {
		logic       rdy;
		logic       mac;
		logic       pm;
		logic       id_wr;
		logic       out_ld;
		logic       flip;
		logic [5:0] cnt;
	} ctl_t;

	typedef struct packed {
		logic       accept;
		logic [2:0] opcode;
		logic       out_busy;
	} stat_t;

	function automatic uword_t ucode(upc_t a);
		uword_t w;
		w        = '0;
		w.jmp    = J_GOTO;
		w.target = U_FETCH;
		unique case (a)
			U_FETCH: begin
				w.rdy = 1'b1;
				w.jmp = J_DISP;
			end
			U_TX: begin
				w.mac    = 1'b1;
				w.jmp    = J_LOOP;
				w.lim    = 6'd15;
				w.target = U_TX_D1;
			end
			U_TX_D1:  w.target = U_TX_D2;
			U_TX_D2:  w.target = U_TX_OUT;
			U_TX_OUT: begin
				w.out_ld = 1'b1;
				w.jmp    = J_WAIT;
			end
			U_PM: begin
				w.mac    = 1'b1;
				w.pm     = 1'b1;
				w.jmp    = J_LOOP;
				w.lim    = 6'd63;
				w.target = U_PM_D1;
			end
			U_PM_D1:   w.target = U_PM_D2;
			U_PM_D2:   w.target = U_PM_FLIP;
			U_PM_FLIP: w.flip   = 1'b1;
			U_ID: begin
				w.id_wr = 1'b1;
				w.jmp   = J_LOOP;
				w.lim   = 6'd15;
			end
			default: begin
				w.jmp = J_GOTO;
			end
		endcase
		return w;
	endfunction

endpackage

/* design/m4xf_if.sv */
// m4xf_req_if and m4xf_rsp_if: valid/ready channels of the transform unit
// no dependencies
interface m4xf_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         opcode;
	logic [3:0]         element_index;
	logic signed [31:0] element_value;
	logic signed [31:0] vec_x;
	logic signed [31:0] vec_y;
	logic signed [31:0] vec_z;
	logic signed [31:0] vec_w;
	logic               last_vector;

	modport source (output valid, opcode, element_index, element_value,
		vec_x, vec_y, vec_z, vec_w, last_vector, input ready);
	modport sink (input valid, opcode, element_index, element_value,
		vec_x, vec_y, vec_z, vec_w, last_vector, output ready);
endinterface

interface m4xf_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic signed [31:0] out_w;
	logic               batch_end;

	modport source (output valid, out_x, out_y, out_z, out_w, batch_end, input ready);
	modport sink (input valid, out_x, out_y, out_z, out_w, batch_end, output ready);
endinterface

/* design/m4xf_seq.sv */
// m4xf_seq: microcode sequencer, step register, loop counter and jump logic
// depends on m4xf_pkg
module m4xf_seq
	import m4xf_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctl_t  ctl
);

	upc_t       upc_q;
	logic [5:0] cnt_q;
	uword_t     w;

	always_comb begin
		w = ucode(upc_q);
	end

	assign ctl.rdy    = w.rdy;
	assign ctl.mac    = w.mac;
	assign ctl.pm     = w.pm;
	assign ctl.id_wr  = w.id_wr;
	assign ctl.out_ld = w.out_ld & ~stat.out_busy;
	assign ctl.flip   = w.flip;
	assign ctl.cnt    = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= U_FETCH;
			cnt_q <= '0;
		end else begin
			unique case (w.jmp)
				J_GOTO: upc_q <= w.target;
				J_DISP: begin
					cnt_q <= '0;
					if (stat.accept) begin
						unique case (stat.opcode)
							OP_PREMUL: upc_q <= U_PM;
							OP_XFORM:  upc_q <= U_TX;
							OP_IDENT:  upc_q <= U_ID;
							default:   upc_q <= U_FETCH;
						endcase
					end
				end
				J_LOOP: begin
					if (cnt_q == w.lim) begin
						cnt_q <= '0;
						upc_q <= w.target;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				J_WAIT: begin
					if (!stat.out_busy) begin
						upc_q <= w.target;
					end
				end
				default: upc_q <= U_FETCH;
			endcase
		end
	end

endmodule

/* design/m4xf_dp.sv */
// m4xf_dp: matrix registers, pipelined multiply-accumulate unit and output register
// depends on m4xf_pkg, m4xf_if; driven by the control word from m4xf_seq
module m4xf_dp
	import m4xf_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  ctl_t          ctl,
	output stat_t         stat,
	m4xf_req_if.sink      req,
	m4xf_rsp_if.source    rsp
);

	logic signed [31:0] cur_q [2][16];
	logic signed [31:0] opd_q [16];
	logic               sel_q;
	logic signed [31:0] vec_q [4];
	logic               last_q;
	logic signed [31:0] res_q [4];

	logic               accept;
	logic [3:0]         cur_addr;
	logic [3:0]         opd_addr;
	logic signed [31:0] a_op;
	logic signed [31:0] b_op;

	logic signed [63:0] prod_s1;
	logic               vld_s1;
	logic               first_s1;
	logic               last_s1;
	logic               pm_s1;
	logic [3:0]         dst_s1;

	logic signed [ACC_W-1:0] acc_s2;
	logic                    wr_s2;
	logic                    pm_s2;
	logic [3:0]              dst_s2;

	logic signed [63:0]      prnd;
	logic signed [47:0]      rnd;
	logic signed [ACC_W-1:0] rnd_ext;
	logic signed [31:0]      sat_val;

	logic               out_valid_q;
	logic signed [31:0] out_q [4];
	logic               out_last_q;

	assign req.ready = ctl.rdy;
	assign accept    = req.valid & ctl.rdy;

	assign stat.accept   = accept;
	assign stat.opcode   = req.opcode;
	assign stat.out_busy = out_valid_q & ~rsp.ready;

	// transform: a = cur[r + 4k], b = v[k]; premultiply: a = opd[r + 4k], b = cur[k + 4c]
	assign opd_addr = {ctl.cnt[1:0], ctl.cnt[3:2]};
	assign cur_addr = ctl.pm ? {ctl.cnt[5:4], ctl.cnt[1:0]} : opd_addr;
	assign a_op     = ctl.pm ? opd_q[opd_addr] : cur_q[sel_q][cur_addr];
	assign b_op     = ctl.pm ? cur_q[sel_q][cur_addr] : vec_q[ctl.cnt[1:0]];

	assign prnd    = prod_s1 + RND_HALF;
	assign rnd     = prnd[63:16];
	assign rnd_ext = {{(ACC_W - 48){rnd[47]}}, rnd};

	always_comb begin
		if ((&acc_s2[ACC_W-1:31]) || !(|acc_s2[ACC_W-1:31])) begin
			sat_val = acc_s2[31:0];
		end else if (acc_s2[ACC_W-1]) begin
			sat_val = SAT_MIN;
		end else begin
			sat_val = SAT_MAX;
		end
	end

	// multiply stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctl.mac;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= a_op * b_op;
		first_s1 <= (ctl.cnt[1:0] == 2'd0);
		last_s1  <= (ctl.cnt[1:0] == 2'd3);
		pm_s1    <= ctl.pm;
		dst_s1   <= ctl.cnt[5:2];
	end

	// round and accumulate stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s2 <= 1'b0;
		end else begin
			wr_s2 <= vld_s1 & last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			acc_s2 <= first_s1 ? rnd_ext : acc_s2 + rnd_ext;
		end
		pm_s2  <= pm_s1;
		dst_s2 <= dst_s1;
	end

	// matrix state and write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
			for (int i = 0; i < 16; i++) begin
				cur_q[0][i] <= (i % 5 == 0) ? Q_ONE : '0;
				cur_q[1][i] <= (i % 5 == 0) ? Q_ONE : '0;
				opd_q[i]    <= '0;
			end
		end else begin
			if (ctl.flip) begin
				sel_q <= ~sel_q;
			end
			if (wr_s2 && pm_s2) begin
				cur_q[~sel_q][dst_s2] <= sat_val;
			end else if (ctl.id_wr) begin
				cur_q[sel_q][ctl.cnt[3:0]] <=
					(ctl.cnt[1:0] == ctl.cnt[3:2]) ? Q_ONE : '0;
			end else if (accept && req.opcode == OP_WR_CUR) begin
				cur_q[sel_q][req.element_index] <= req.element_value;
			end
			if (accept && req.opcode == OP_WR_OPD) begin
				opd_q[req.element_index] <= req.element_value;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && req.opcode == OP_XFORM) begin
			vec_q[0] <= req.vec_x;
			vec_q[1] <= req.vec_y;
			vec_q[2] <= req.vec_z;
			vec_q[3] <= req.vec_w;
			last_q   <= req.last_vector;
		end
		if (wr_s2 && !pm_s2) begin
			res_q[dst_s2[1:0]] <= sat_val;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_ld) begin
			out_q      <= res_q;
			out_last_q <= last_q;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.out_x     = out_q[0];
	assign rsp.out_y     = out_q[1];
	assign rsp.out_z     = out_q[2];
	assign rsp.out_w     = out_q[3];
	assign rsp.batch_end = out_last_q;

`ifndef SYNTHESIS
	a_ld_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_ld |-> !(out_valid_q && !rsp.ready))
		else $error("pending result overwritten");

	a_ld_drained: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_ld |-> (!vld_s1 && !wr_s2 && !ctl.mac))
		else $error("result loaded before accumulation finished");

	a_flip_drained: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.flip |-> (!vld_s1 && !wr_s2))
		else $error("bank swap with premultiply in flight");

	a_idle_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rdy |-> (!vld_s1 && !wr_s2 && !ctl.id_wr))
		else $error("request taken while datapath busy");
`endif

endmodule

/* design/matrix4x4_transform_unit.sv */
// matrix4x4_transform_unit: top level, microcoded sequencer driving the datapath
// depends on m4xf_pkg, m4xf_if, m4xf_seq, m4xf_dp
//
// Holds a 4x4 signed Q16.16 matrix in column-major order (element r + 4c), reset to
// identity, plus an operand matrix reset to zero. A single 32x32 multiplier with
// round-to-nearest (half up) and a 50-bit accumulator with saturated write-back does
// all products, stepped by a ten-word microprogram. Element writes land on acceptance,
// identity reload rewrites all 16 elements, a transform runs an issue slot, 16
// multiply-accumulate passes, a pipeline drain and an output load, and premultiply
// 64 passes into the spare bank, then swapped in. Only transforms produce a response,
// held in an output register so the next request can be taken while it waits; a
// later transform holds in its final step until the previous response is taken.
module matrix4x4_transform_unit
	import m4xf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	m4xf_req_if.sink   req,
	m4xf_rsp_if.source rsp
);

	ctl_t  ctl;
	stat_t stat;

	m4xf_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	m4xf_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.stat   (stat),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
